[design/jhn_pkg.sv]
// Shared types, constants and helpers of the joint histogram NMI block.
package jhn_pkg;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 2048;
    localparam int BIN_COUNT     = 32;
    localparam int LOG_FRAC_BITS = 16;

    localparam int GREY_W      = 8;
    localparam int SIZE_W      = 12;
    localparam int POS_W       = 11;
    localparam int BIN_W       = $clog2(BIN_COUNT);
    localparam int JOINT_DEPTH = BIN_COUNT * BIN_COUNT;
    localparam int JIDX_W      = 2 * BIN_W;
    localparam int CNT_W       = 23;
    localparam int EXP_W       = 5;
    localparam int LOG_W       = EXP_W + LOG_FRAC_BITS;
    localparam int MANT_W      = 31;
    localparam int FCNT_W      = $clog2(LOG_FRAC_BITS);
    localparam int PROD_W      = CNT_W + LOG_W;
    localparam int ACC_W       = PROD_W + JIDX_W + 1;
    localparam int NUM_W       = PROD_W + 1;
    localparam int QF_BITS     = 30;
    localparam int DVD_W       = NUM_W + QF_BITS;
    localparam int DSTEP_W     = $clog2(DVD_W);
    localparam int NMI_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [NMI_W-1:0] NMI_MAX = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_RED       = 3'd4;

    typedef struct packed {
        logic [GREY_W-1:0] rendered_grey;
        logic [GREY_W-1:0] video_grey;
        logic [GREY_W-1:0] rendered_blue;
        logic [GREY_W-1:0] rendered_green;
        logic [GREY_W-1:0] rendered_red;
        logic              frame_end;
    } in_word_t;

    typedef struct packed {
        logic [NMI_W-1:0] nmi_value;
        logic [CNT_W-1:0] sample_count;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR,
        ST_NL,
        ST_NL_WAIT,
        ST_BIN_ADDR,
        ST_BIN_SEL,
        ST_BIN_WAIT,
        ST_BIN_NEXT,
        ST_DIV,
        ST_DIV_WAIT,
        ST_OUT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_ROW,
        PH_COL,
        PH_JOINT
    } phase_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_SQ,
        LG_MUL
    } log_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction

endpackage

[design/joint_histogram_nmi.sv]
// Top level: pixel binning, joint and marginal histograms, entropy sequencer and result.
// A counted pixel also passes through ST_WR, the joint memory read-modify-write.
// A frame_end word then runs the entropy pass: N log N, then over 32 + 32 + 1024 bins
// n log n per nonzero bin (empty bins skipped) in the shared log/multiply unit, then the
// division. Then the result waits in the output word.
// After each result the joint memory is swept to zero, input stalled.
// Reset clears control and counters and starts the same clearing sweep.
module joint_histogram_nmi (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jhn_pkg::in_word_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output jhn_pkg::out_word_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [jhn_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [jhn_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int CW = jhn_pkg::CNT_W;
    localparam int SW = jhn_pkg::SIZE_W;
    localparam int PW = jhn_pkg::POS_W;
    localparam int BW = jhn_pkg::BIN_W;
    localparam int JW = jhn_pkg::JIDX_W;
    localparam int BC = jhn_pkg::BIN_COUNT;

    jhn_pkg::seq_state_t state_reg, state_next;
    jhn_pkg::phase_t     phase_reg, phase_next;

    logic [SW-1:0] width_reg, height_reg;
    logic [7:0]    bg_blue_reg, bg_green_reg, bg_red_reg;

    logic [PW-1:0] col_reg, col_next, row_reg, row_next;
    logic [CW-1:0] counted_reg, counted_next;
    logic [CW-1:0] rend_reg [BC];
    logic [CW-1:0] rend_next [BC];
    logic [CW-1:0] vid_reg [BC];
    logic [CW-1:0] vid_next [BC];
    logic [JW-1:0] idx_reg, idx_next;
    logic [JW-1:0] addr_reg, addr_next;
    logic          last_reg, last_next;

    logic [jhn_pkg::PROD_W-1:0] nl_reg, nl_next;
    logic [jhn_pkg::ACC_W-1:0]  acc_reg, acc_next;
    logic [jhn_pkg::PROD_W-1:0] hr_reg, hr_next, hc_reg, hc_next, hj_reg, hj_next;
    logic                       out_valid_reg, out_valid_next;
    jhn_pkg::out_word_t         out_word_reg, out_word_next;
    logic [jhn_pkg::NMI_W-1:0]  nmi_reg, nmi_next;

    logic [CW-1:0] joint_mem [jhn_pkg::JOINT_DEPTH];
    logic [CW-1:0] rd_data_reg;
    logic          mem_we;
    logic [JW-1:0] mem_waddr, mem_raddr;
    logic [CW-1:0] mem_wdata;

    logic [SW-1:0] w_eff, h_eff, col_inc, row_inc;
    logic          border, bg, in_acc, count_en;
    logic [BW-1:0] bin_a, bin_b;
    logic [CW-1:0] bin_val;
    logic [JW-1:0] idx_last;
    logic [jhn_pkg::ACC_W-1:0]  nl_ext;
    logic [jhn_pkg::PROD_W-1:0] h_phase;

    logic                       log_start, log_done;
    logic [CW-1:0]              log_n;
    logic [jhn_pkg::PROD_W-1:0] log_result;
    logic                       div_start, div_done;
    logic [jhn_pkg::NMI_W-1:0]  div_q;

    jhn_log_mul u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .n      (log_n),
        .done   (log_done),
        .result (log_result)
    );

    jhn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      ({1'b0, hr_reg} + {1'b0, hc_reg}),
        .den      (hj_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SW'(640);
            height_reg   <= SW'(480);
            bg_blue_reg  <= 8'd255;
            bg_green_reg <= 8'd0;
            bg_red_reg   <= 8'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                jhn_pkg::CFG_IMAGE_WIDTH:  width_reg    <= cfg_data;
                jhn_pkg::CFG_IMAGE_HEIGHT: height_reg   <= cfg_data;
                jhn_pkg::CFG_BG_BLUE:      bg_blue_reg  <= cfg_data[7:0];
                jhn_pkg::CFG_BG_GREEN:     bg_green_reg <= cfg_data[7:0];
                jhn_pkg::CFG_BG_RED:       bg_red_reg   <= cfg_data[7:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            joint_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= joint_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jhn_pkg::ST_CLEAR;
            phase_reg     <= jhn_pkg::PH_ROW;
            col_reg       <= '0;
            row_reg       <= '0;
            counted_reg   <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < BC; k++)
            begin
                rend_reg[k] <= '0;
                vid_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            counted_reg   <= counted_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < BC; k++)
            begin
                rend_reg[k] <= rend_next[k];
                vid_reg[k]  <= vid_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg     <= addr_next;
        last_reg     <= last_next;
        nl_reg       <= nl_next;
        acc_reg      <= acc_next;
        hr_reg       <= hr_next;
        hc_reg       <= hc_next;
        hj_reg       <= hj_next;
        nmi_reg      <= nmi_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        w_eff = (width_reg > SW'(jhn_pkg::MAX_WIDTH)) ? SW'(jhn_pkg::MAX_WIDTH) :
                ((width_reg == '0) ? SW'(1) : width_reg);
        h_eff = (height_reg > SW'(jhn_pkg::MAX_HEIGHT)) ? SW'(jhn_pkg::MAX_HEIGHT) :
                ((height_reg == '0) ? SW'(1) : height_reg);
        col_inc = SW'(col_reg) + SW'(1);
        row_inc = SW'(row_reg) + SW'(1);
        border  = (col_reg == '0) || (col_inc >= w_eff) ||
                  (row_reg == '0) || (row_inc >= h_eff);
        bg      = (in_data.rendered_blue == bg_blue_reg) &&
                  (in_data.rendered_green == bg_green_reg) &&
                  (in_data.rendered_red == bg_red_reg);
        in_acc   = in_valid && (state_reg == jhn_pkg::ST_IDLE);
        count_en = in_acc && !border && !bg;
        bin_a    = in_data.rendered_grey[jhn_pkg::GREY_W-1 -: BW];
        bin_b    = in_data.video_grey[jhn_pkg::GREY_W-1 -: BW];
        nl_ext   = jhn_pkg::ACC_W'(nl_reg);
        h_phase  = (nl_ext > acc_reg) ? jhn_pkg::PROD_W'(nl_ext - acc_reg) : '0;
        idx_last = (phase_reg == jhn_pkg::PH_JOINT) ? '1 : JW'(BC - 1);
        case (phase_reg)
            jhn_pkg::PH_ROW: bin_val = rend_reg[idx_reg[BW-1:0]];
            jhn_pkg::PH_COL: bin_val = vid_reg[idx_reg[BW-1:0]];
            default:         bin_val = rd_data_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        counted_next   = counted_reg;
        rend_next      = rend_reg;
        vid_next       = vid_reg;
        idx_next       = idx_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        nl_next        = nl_reg;
        acc_next       = acc_reg;
        hr_next        = hr_reg;
        hc_next        = hc_reg;
        hj_next        = hj_reg;
        nmi_next       = nmi_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = jhn_pkg::sat_inc(rd_data_reg);
        mem_raddr      = idx_reg;
        log_start      = 1'b0;
        log_n          = bin_val;
        div_start      = 1'b0;
        in_stall       = (state_reg != jhn_pkg::ST_IDLE);

        case (state_reg)
            jhn_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
                idx_next  = idx_reg + JW'(1);
                if (idx_reg == '1)
                begin
                    state_next = jhn_pkg::ST_IDLE;
                end
            end
            jhn_pkg::ST_IDLE:
            begin
                mem_raddr = {bin_a, bin_b};
                if (in_acc)
                begin
                    addr_next = {bin_a, bin_b};
                    last_next = in_data.frame_end;
                    if (count_en)
                    begin
                        counted_next = jhn_pkg::sat_inc(counted_reg);
                        for (int k = 0; k < BC; k++)
                        begin
                            if (bin_a == BW'(k))
                            begin
                                rend_next[k] = jhn_pkg::sat_inc(rend_reg[k]);
                            end
                            if (bin_b == BW'(k))
                            begin
                                vid_next[k] = jhn_pkg::sat_inc(vid_reg[k]);
                            end
                        end
                    end
                    if (!in_data.frame_end)
                    begin
                        if (col_inc >= w_eff)
                        begin
                            col_next = '0;
                            row_next = (row_inc >= h_eff) ? '0 : PW'(row_inc);
                        end
                        else
                        begin
                            col_next = PW'(col_inc);
                        end
                    end
                    if (count_en)
                    begin
                        state_next = jhn_pkg::ST_WR;
                    end
                    else if (in_data.frame_end)
                    begin
                        state_next = jhn_pkg::ST_NL;
                    end
                end
            end
            jhn_pkg::ST_WR:
            begin
                mem_we     = 1'b1;
                state_next = last_reg ? jhn_pkg::ST_NL : jhn_pkg::ST_IDLE;
            end
            jhn_pkg::ST_NL:
            begin
                if (counted_reg == '0)
                begin
                    nmi_next   = '0;
                    state_next = jhn_pkg::ST_OUT;
                end
                else
                begin
                    log_start  = 1'b1;
                    log_n      = counted_reg;
                    state_next = jhn_pkg::ST_NL_WAIT;
                end
            end
            jhn_pkg::ST_NL_WAIT:
            begin
                if (log_done)
                begin
                    nl_next    = log_result;
                    acc_next   = '0;
                    idx_next   = '0;
                    phase_next = jhn_pkg::PH_ROW;
                    state_next = jhn_pkg::ST_BIN_ADDR;
                end
            end
            jhn_pkg::ST_BIN_ADDR:
            begin
                state_next = jhn_pkg::ST_BIN_SEL;
            end
            jhn_pkg::ST_BIN_SEL:
            begin
                if (bin_val != '0)
                begin
                    log_start  = 1'b1;
                    state_next = jhn_pkg::ST_BIN_WAIT;
                end
                else
                begin
                    state_next = jhn_pkg::ST_BIN_NEXT;
                end
            end
            jhn_pkg::ST_BIN_WAIT:
            begin
                if (log_done)
                begin
                    acc_next   = acc_reg + jhn_pkg::ACC_W'(log_result);
                    state_next = jhn_pkg::ST_BIN_NEXT;
                end
            end
            jhn_pkg::ST_BIN_NEXT:
            begin
                idx_next   = idx_reg + JW'(1);
                state_next = jhn_pkg::ST_BIN_ADDR;
                if (idx_reg == idx_last)
                begin
                    idx_next = '0;
                    acc_next = '0;
                    case (phase_reg)
                        jhn_pkg::PH_ROW:
                        begin
                            hr_next    = h_phase;
                            phase_next = jhn_pkg::PH_COL;
                        end
                        jhn_pkg::PH_COL:
                        begin
                            hc_next    = h_phase;
                            phase_next = jhn_pkg::PH_JOINT;
                        end
                        default:
                        begin
                            hj_next    = h_phase;
                            phase_next = jhn_pkg::PH_ROW;
                            state_next = jhn_pkg::ST_DIV;
                        end
                    endcase
                end
            end
            jhn_pkg::ST_DIV:
            begin
                if (hj_reg == '0)
                begin
                    nmi_next   = jhn_pkg::NMI_MAX;
                    state_next = jhn_pkg::ST_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = jhn_pkg::ST_DIV_WAIT;
                end
            end
            jhn_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    nmi_next   = div_q;
                    state_next = jhn_pkg::ST_OUT;
                end
            end
            jhn_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.nmi_value    = nmi_reg;
                    out_word_next.sample_count = counted_reg;
                    counted_next               = '0;
                    col_next                   = '0;
                    row_next                   = '0;
                    idx_next                   = '0;
                    for (int k = 0; k < BC; k++)
                    begin
                        rend_next[k] = '0;
                        vid_next[k]  = '0;
                    end
                    state_next = jhn_pkg::ST_CLEAR;
                end
            end
            default:
            begin
                state_next = jhn_pkg::ST_CLEAR;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

[design/jhn_log_mul.sv]
// Shared multiplier unit: n * log2(n) by normalize, repeated squaring, product.
module jhn_log_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [jhn_pkg::CNT_W-1:0]  n,
    output logic                       done,
    output logic [jhn_pkg::PROD_W-1:0] result
);

    localparam int MW = jhn_pkg::MANT_W;

    jhn_pkg::log_state_t state_reg, state_next;
    logic [jhn_pkg::CNT_W-1:0]         n_reg, n_next;
    logic [MW-1:0]                     m_reg, m_next;
    logic [jhn_pkg::EXP_W-1:0]         e_reg, e_next;
    logic [jhn_pkg::LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [jhn_pkg::FCNT_W-1:0]        cnt_reg, cnt_next;
    logic [jhn_pkg::PROD_W-1:0]        result_reg, result_next;
    logic                              done_reg, done_next;
    logic [MW-1:0]                     mul_a, mul_b;
    logic [2*MW-1:0]                   prod;
    logic [MW:0]                       sq;

    assign prod = (2*MW)'(mul_a) * (2*MW)'(mul_b);
    assign sq   = prod[2*MW-1:MW-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= jhn_pkg::LG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        m_reg      <= m_next;
        e_reg      <= e_next;
        frac_reg   <= frac_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        m_next      = m_reg;
        e_next      = e_reg;
        frac_next   = frac_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        case (state_reg)
            jhn_pkg::LG_IDLE:
            begin
                if (start)
                begin
                    n_next     = n;
                    m_next     = MW'(n);
                    e_next     = jhn_pkg::EXP_W'(MW - 1);
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = jhn_pkg::LG_NORM;
                end
            end
            jhn_pkg::LG_NORM:
            begin
                if (m_reg[MW-1])
                begin
                    state_next = jhn_pkg::LG_SQ;
                end
                else
                begin
                    m_next = {m_reg[MW-2:0], 1'b0};
                    e_next = e_reg - jhn_pkg::EXP_W'(1);
                end
            end
            jhn_pkg::LG_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
                if (sq[MW])
                begin
                    m_next = sq[MW:1];
                end
                else
                begin
                    m_next = sq[MW-1:0];
                end
                frac_next = {frac_reg[jhn_pkg::LOG_FRAC_BITS-2:0], sq[MW]};
                cnt_next  = cnt_reg + jhn_pkg::FCNT_W'(1);
                if (cnt_reg == jhn_pkg::FCNT_W'(jhn_pkg::LOG_FRAC_BITS - 1))
                begin
                    state_next = jhn_pkg::LG_MUL;
                end
            end
            jhn_pkg::LG_MUL:
            begin
                mul_a       = MW'(n_reg);
                mul_b       = MW'({e_reg, frac_reg});
                result_next = prod[jhn_pkg::PROD_W-1:0];
                done_next   = 1'b1;
                state_next  = jhn_pkg::LG_IDLE;
            end
            default:
            begin
                state_next = jhn_pkg::LG_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[design/jhn_div.sv]
// Restoring divider: floor(num * 2^30 / den), one quotient bit per cycle, saturated at 2.0.
module jhn_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [jhn_pkg::NUM_W-1:0]  num,
    input  logic [jhn_pkg::PROD_W-1:0] den,
    output logic                       done,
    output logic [jhn_pkg::NMI_W-1:0]  quotient
);

    localparam int HW = jhn_pkg::PROD_W;
    localparam int QW = jhn_pkg::NMI_W;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [jhn_pkg::DSTEP_W-1:0] cnt_reg, cnt_next;
    logic [jhn_pkg::DVD_W-1:0]   dvd_reg, dvd_next;
    logic [HW-1:0]               rem_reg, rem_next;
    logic [HW-1:0]               den_reg, den_next;
    logic [QW:0]                 q_reg, q_next;
    logic                        ovf_reg, ovf_next;
    logic [HW:0]                 r2;
    logic                        ge;

    assign r2 = {rem_reg, dvd_reg[jhn_pkg::DVD_W-1]};
    assign ge = r2 >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next = 1'b1;
                cnt_next  = '0;
                dvd_next  = {num, jhn_pkg::QF_BITS'(0)};
                rem_next  = '0;
                den_next  = den;
                q_next    = '0;
                ovf_next  = 1'b0;
            end
        end
        else
        begin
            rem_next = ge ? HW'(r2 - {1'b0, den_reg}) : r2[HW-1:0];
            dvd_next = {dvd_reg[jhn_pkg::DVD_W-2:0], 1'b0};
            q_next   = {q_reg[QW-1:0], ge};
            ovf_next = ovf_reg | q_reg[QW];
            cnt_next = cnt_reg + jhn_pkg::DSTEP_W'(1);
            if (cnt_reg == jhn_pkg::DSTEP_W'(jhn_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = (ovf_reg || q_reg > {1'b0, jhn_pkg::NMI_MAX}) ?
                      jhn_pkg::NMI_MAX : q_reg[QW-1:0];

endmodule
